// ----- rtl/pcm_pkg.sv -----
package pcm_pkg;

  // Default build of the block
  localparam int DEFAULT_MAX_ITEMS   = 1024;
  localparam int DEFAULT_SAMPLE_BITS = 16;

  // Fixed port widths
  localparam int PORT_SAMPLE_W = 16;
  localparam int PAIR_COUNT_W  = 11;

  // Fraction bits of the Q1.15 result; the result needs one more bit for 1.0
  localparam int FRAC_BITS = 15;
  localparam int RESULT_W  = FRAC_BITS + 1;

endpackage

// ----- rtl/pcm_mul.sv -----
module pcm_mul #(
  parameter int OP_W = 53
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [OP_W-1:0]   a,
  input  logic [OP_W-1:0]   b,
  output logic              done,
  output logic [2*OP_W-1:0] product
);

  logic              busy;
  logic [2*OP_W-1:0] mcand;
  logic [OP_W-1:0]   mplier;

  // Shift-add over the bits of b; stop once the remaining bits are all zero
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= !start && busy && (mplier[OP_W-1:1] == '0);
      if (start) begin
        busy    <= 1'b1;
        product <= '0;
        mcand   <= {{OP_W{1'b0}}, a};
        mplier  <= b;
      end else if (busy) begin
        if (mplier[0]) begin
          product <= product + mcand;
        end
        mcand  <= mcand << 1;
        mplier <= mplier >> 1;
        if (mplier[OP_W-1:1] == '0) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

// ----- rtl/pcm_root.sv -----
module pcm_root #(
  parameter int IN_W = 106
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [IN_W-1:0]              num_sq,
  input  logic [IN_W-1:0]              den,
  output logic                         done,
  output logic [pcm_pkg::RESULT_W-1:0] root
);

  localparam int SH    = 2 * pcm_pkg::FRAC_BITS;
  localparam int LW    = IN_W + SH;
  localparam int QB    = SH + 1;
  localparam int CNT_W = $clog2(QB);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_DIV,
    PH_SQRT
  } phase_t;

  phase_t           phase;
  logic [LW-1:0]    rem;
  logic [LW-1:0]    dvs;
  logic [QB-1:0]    quo;
  logic [QB:0]      res;
  logic [QB:0]      one;
  logic [CNT_W-1:0] step;

  logic             div_fit;
  logic [QB:0]      cand;
  logic             sq_fit;
  logic [QB:0]      res_next;

  // One restoring step of the divide and of the square root
  always_comb begin
    div_fit  = (rem >= dvs);
    cand     = res + one;
    sq_fit   = ({1'b0, quo} >= cand);
    res_next = sq_fit ? ((res >> 1) + one) : (res >> 1);
  end

  // Divide num_sq * 2^30 by den, then take the integer square root
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      done  <= 1'b0;
    end else begin
      done <= (phase == PH_SQRT) && (step == '0);
      unique case (phase)
        PH_IDLE: begin
          if (start) begin
            rem   <= {num_sq, {SH{1'b0}}};
            dvs   <= {den, {SH{1'b0}}};
            quo   <= '0;
            step  <= CNT_W'(QB - 1);
            phase <= PH_DIV;
          end
        end
        PH_DIV: begin
          if (div_fit) begin
            rem <= rem - dvs;
          end
          quo  <= {quo[QB-2:0], div_fit};
          dvs  <= dvs >> 1;
          step <= step - 1'b1;
          if (step == '0) begin
            res   <= '0;
            one   <= (QB + 1)'(1) << SH;
            step  <= CNT_W'(pcm_pkg::FRAC_BITS);
            phase <= PH_SQRT;
          end
        end
        PH_SQRT: begin
          if (sq_fit) begin
            quo <= quo - cand[QB-1:0];
          end
          res  <= res_next;
          one  <= one >> 2;
          step <= step - 1'b1;
          if (step == '0) begin
            root  <= res_next[pcm_pkg::RESULT_W-1:0];
            phase <= PH_IDLE;
          end
        end
        default: begin
          phase <= PH_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- rtl/pearson_correlation_magnitude.sv -----
// Absolute Pearson correlation of a run of (data, model) intensity pairs. Pairs
// are taken one per clock and added to exact sums of x, y, xy, x^2 and y^2; a
// pair with last set closes the set, and the block stalls its input while it
// works out floor(|n*Sxy - Sx*Sy| * 32768 / sqrt(dx*dy)) in unsigned Q1.15.
// That work runs on one shared bit-serial shift-add multiplier for eight wide
// products, each of which runs only through the significant bits of its
// multiplier operand (at most 2*(min(SAMPLE_BITS, 16) + clog2(MAX_ITEMS+1))
// bits), then a 31-step restoring divide and a 16-step square root; the work is
// far shorter when either variance is zero or the set overflowed. The result
// waits in an output register, so accumulation of the next set goes on while it
// is held; pairs beyond MAX_ITEMS are dropped, and the result then reads 0 with
// overflow set.
module pearson_correlation_magnitude #(
  parameter int MAX_ITEMS   = pcm_pkg::DEFAULT_MAX_ITEMS,
  parameter int SAMPLE_BITS = pcm_pkg::DEFAULT_SAMPLE_BITS
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [pcm_pkg::PORT_SAMPLE_W-1:0] data_value,
  input  logic [pcm_pkg::PORT_SAMPLE_W-1:0] model_value,
  input  logic                             last,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [pcm_pkg::RESULT_W-1:0]     correlation_magnitude,
  output logic                             zero_variance,
  output logic                             overflow,
  output logic [pcm_pkg::PAIR_COUNT_W-1:0] pair_count
);

  localparam int XW = (SAMPLE_BITS < pcm_pkg::PORT_SAMPLE_W) ?
                      SAMPLE_BITS : pcm_pkg::PORT_SAMPLE_W;
  localparam int CW = $clog2(MAX_ITEMS + 1);
  localparam int SW = XW + CW;
  localparam int QW = 2 * XW + CW;
  localparam int PW = CW + QW;
  localparam int DW = 2 * PW;

  typedef enum logic [2:0] {
    ST_ACC,
    ST_FLUSH,
    ST_MUL,
    ST_CHECK,
    ST_ROOT,
    ST_DONE
  } state_t;

  typedef enum logic [2:0] {
    OP_NSXY,
    OP_SXSY,
    OP_NSXX,
    OP_SXSX,
    OP_NSYY,
    OP_SYSY,
    OP_DEN,
    OP_NUMSQ
  } op_t;

  state_t state;
  op_t    op;
  logic   issued;

  // Accumulator state
  logic [CW-1:0]   count;
  logic            overflowed;
  logic [SW-1:0]   sum_data;
  logic [SW-1:0]   sum_model;
  logic [QW-1:0]   sum_cross;
  logic [QW-1:0]   sum_data_squared;
  logic [QW-1:0]   sum_model_squared;
  logic            pend;
  logic [XW-1:0]   x_r;
  logic [XW-1:0]   y_r;
  logic [2*XW-1:0] xy_p;
  logic [2*XW-1:0] xx_p;
  logic [2*XW-1:0] yy_p;

  // Final computation
  logic [PW-1:0] tmp;
  logic [PW-1:0] num;
  logic [PW-1:0] dx;
  logic [PW-1:0] dy;
  logic [DW-1:0] den;
  logic [DW-1:0] numsq;
  logic [pcm_pkg::RESULT_W-1:0] result_r;
  logic          zvar;

  logic          accept;
  logic          out_free;
  logic          clear;
  logic          mul_start;
  logic [PW-1:0] mul_a;
  logic [PW-1:0] mul_b;
  logic          mul_done;
  logic [DW-1:0] mul_prod;
  logic [PW-1:0] mul_lo;
  logic          root_start;
  logic          root_done;
  logic [pcm_pkg::RESULT_W-1:0] root;

  assign in_stall   = (state != ST_ACC);
  assign accept     = in_valid && !in_stall;
  assign out_free   = !out_valid || !out_stall;
  assign clear      = (state == ST_DONE) && out_free;
  assign mul_start  = (state == ST_MUL) && !issued;
  assign root_start = (state == ST_ROOT) && !issued;
  assign mul_lo     = mul_prod[PW-1:0];

  assign xy_p = x_r * y_r;
  assign xx_p = x_r * x_r;
  assign yy_p = y_r * y_r;

  // Take a pair, drop it once the set is full, add the held pair on the next clock
  always_ff @(posedge clk) begin
    if (rst) begin
      pend              <= 1'b0;
      count             <= '0;
      overflowed        <= 1'b0;
      sum_data          <= '0;
      sum_model         <= '0;
      sum_cross         <= '0;
      sum_data_squared  <= '0;
      sum_model_squared <= '0;
    end else if (clear) begin
      pend              <= 1'b0;
      count             <= '0;
      overflowed        <= 1'b0;
      sum_data          <= '0;
      sum_model         <= '0;
      sum_cross         <= '0;
      sum_data_squared  <= '0;
      sum_model_squared <= '0;
    end else begin
      pend <= accept && (count < CW'(MAX_ITEMS));
      if (accept) begin
        if (count >= CW'(MAX_ITEMS)) begin
          overflowed <= 1'b1;
        end else begin
          count <= count + 1'b1;
          x_r   <= data_value[XW-1:0];
          y_r   <= model_value[XW-1:0];
        end
      end
      if (pend) begin
        sum_data          <= sum_data + {{CW{1'b0}}, x_r};
        sum_model         <= sum_model + {{CW{1'b0}}, y_r};
        sum_cross         <= sum_cross + {{CW{1'b0}}, xy_p};
        sum_data_squared  <= sum_data_squared + {{CW{1'b0}}, xx_p};
        sum_model_squared <= sum_model_squared + {{CW{1'b0}}, yy_p};
      end
    end
  end

  // Pick the operands of the current product
  always_comb begin
    unique case (op)
      OP_NSXY: begin
        mul_a = PW'(sum_cross);
        mul_b = PW'(count);
      end
      OP_SXSY: begin
        mul_a = PW'(sum_data);
        mul_b = PW'(sum_model);
      end
      OP_NSXX: begin
        mul_a = PW'(sum_data_squared);
        mul_b = PW'(count);
      end
      OP_SXSX: begin
        mul_a = PW'(sum_data);
        mul_b = PW'(sum_data);
      end
      OP_NSYY: begin
        mul_a = PW'(sum_model_squared);
        mul_b = PW'(count);
      end
      OP_SYSY: begin
        mul_a = PW'(sum_model);
        mul_b = PW'(sum_model);
      end
      OP_DEN: begin
        mul_a = dx;
        mul_b = dy;
      end
      OP_NUMSQ: begin
        mul_a = num;
        mul_b = num;
      end
    endcase
  end

  pcm_mul #(
    .OP_W (PW)
  ) u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .a       (mul_a),
    .b       (mul_b),
    .done    (mul_done),
    .product (mul_prod)
  );

  pcm_root #(
    .IN_W (DW)
  ) u_root (
    .clk    (clk),
    .rst    (rst),
    .start  (root_start),
    .num_sq (numsq),
    .den    (den),
    .done   (root_done),
    .root   (root)
  );

  // Sequence the products, the divide and root, and the result transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_ACC;
      op        <= OP_NSXY;
      issued    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && (state != ST_DONE)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_ACC: begin
          if (accept && last) begin
            state <= ST_FLUSH;
          end
        end
        ST_FLUSH: begin
          op     <= OP_NSXY;
          issued <= 1'b0;
          state  <= ST_MUL;
        end
        ST_MUL: begin
          if (mul_done) begin
            issued <= 1'b0;
            unique case (op)
              OP_NSXY: begin
                tmp <= mul_lo;
                op  <= OP_SXSY;
              end
              OP_SXSY: begin
                num <= (tmp >= mul_lo) ? (tmp - mul_lo) : (mul_lo - tmp);
                op  <= OP_NSXX;
              end
              OP_NSXX: begin
                tmp <= mul_lo;
                op  <= OP_SXSX;
              end
              OP_SXSX: begin
                dx <= (tmp >= mul_lo) ? (tmp - mul_lo) : '0;
                op <= OP_NSYY;
              end
              OP_NSYY: begin
                tmp <= mul_lo;
                op  <= OP_SYSY;
              end
              OP_SYSY: begin
                dy    <= (tmp >= mul_lo) ? (tmp - mul_lo) : '0;
                state <= ST_CHECK;
              end
              OP_DEN: begin
                den <= mul_prod;
                op  <= OP_NUMSQ;
              end
              OP_NUMSQ: begin
                numsq <= mul_prod;
                state <= ST_ROOT;
              end
            endcase
          end else if (!issued) begin
            issued <= 1'b1;
          end
        end
        ST_CHECK: begin
          zvar <= (dx == '0) || (dy == '0);
          if ((dx == '0) || (dy == '0) || overflowed) begin
            result_r <= '0;
            state    <= ST_DONE;
          end else begin
            op     <= OP_DEN;
            issued <= 1'b0;
            state  <= ST_MUL;
          end
        end
        ST_ROOT: begin
          if (root_done) begin
            issued   <= 1'b0;
            result_r <= root;
            state    <= ST_DONE;
          end else if (!issued) begin
            issued <= 1'b1;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid             <= 1'b1;
            correlation_magnitude <= result_r;
            zero_variance         <= zvar;
            overflow              <= overflowed;
            pair_count            <= pcm_pkg::PAIR_COUNT_W'(count);
            state                 <= ST_ACC;
          end
        end
        default: begin
          state <= ST_ACC;
        end
      endcase
    end
  end

endmodule

// ----- tb/tb_pearson_correlation_magnitude.sv -----
`timescale 1ns / 100ps

module tb_pearson_correlation_magnitude;

  localparam int MAX_ITEMS      = pcm_pkg::DEFAULT_MAX_ITEMS;
  localparam int SAMPLE_BITS    = pcm_pkg::DEFAULT_SAMPLE_BITS;
  localparam int SAMPLE_W       = pcm_pkg::PORT_SAMPLE_W;
  localparam int RES_W          = pcm_pkg::RESULT_W;
  localparam int CNT_W          = pcm_pkg::PAIR_COUNT_W;
  localparam int WIDE_W         = 160;
  localparam int RANDOM_PAIRS   = 430;
  localparam int STALL_PCT      = 12;
  localparam int HOLD_CYCLES    = 1500;
  localparam int HOLD_AFTER     = 12;
  localparam int DRAIN_CYCLES   = 600;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int REPORT_LIMIT   = 10;
  localparam logic [63:0] SAMPLE_MASK = (64'd1 << SAMPLE_BITS) - 64'd1;
  localparam logic [RES_W-1:0] Q_ONE = RES_W'(1) << pcm_pkg::FRAC_BITS;

  typedef struct packed {
    logic [RES_W-1:0] magnitude;
    logic             zero_var;
    logic             ovf;
    logic [CNT_W-1:0] count;
  } corr_result_t;

  typedef enum int {
    SHAPE_RANDOM,
    SHAPE_SMALL,
    SHAPE_EXTREME,
    SHAPE_SAME,
    SHAPE_MIRROR,
    SHAPE_HALF,
    SHAPE_FLAT_DATA,
    SHAPE_FLAT_MODEL
  } set_shape_t;

  // Exact running sums of the open set and the queue of correlations owed
  class corr_scoreboard;
    logic [63:0] sum_x, sum_y, sum_xy, sum_xx, sum_yy;
    logic [31:0] pairs;
    bit dropped;
    corr_result_t pending_results[$];
    int errors;

    function new();
      clear();
      errors = 0;
    endfunction

    function void clear();
      sum_x = 0;
      sum_y = 0;
      sum_xy = 0;
      sum_xx = 0;
      sum_yy = 0;
      pairs = 0;
      dropped = 0;
    endfunction

    // n*sum of squares - sum^2, floored at zero
    function logic [WIDE_W-1:0] spread(logic [WIDE_W-1:0] n, logic [WIDE_W-1:0] sq,
                                       logic [WIDE_W-1:0] s);
      logic [WIDE_W-1:0] p, q;
      p = n * sq;
      q = s * s;
      return (p < q) ? '0 : p - q;
    endfunction

    // Largest r in [0, 1.0] with r^2 * dx * dy <= num^2 * 2^30
    function logic [RES_W-1:0] root_ratio(logic [WIDE_W-1:0] num,
                                          logic [WIDE_W-1:0] dx,
                                          logic [WIDE_W-1:0] dy);
      logic [WIDE_W-1:0] den, lhs, wide_mid;
      int unsigned lo, hi, mid;
      den = dx * dy;
      lhs = (num * num) << 30;
      lo = 0;
      hi = 32'(Q_ONE);
      while (lo < hi) begin
        mid = (lo + hi + 1) / 2;
        wide_mid = WIDE_W'(mid);
        if (wide_mid * wide_mid * den <= lhs) lo = mid;
        else hi = mid - 1;
      end
      return lo[RES_W-1:0];
    endfunction

    // Accumulate one accepted pair; close the set on last
    function void note_pair(logic [SAMPLE_W-1:0] data, logic [SAMPLE_W-1:0] model,
                            logic is_last);
      logic [63:0] x, y;
      logic [WIDE_W-1:0] n, wx, wy, wxy, wxx, wyy, num, dx, dy, p, q;
      corr_result_t r;
      x = data & SAMPLE_MASK;
      y = model & SAMPLE_MASK;
      if (pairs >= MAX_ITEMS) begin
        dropped = 1;
      end else begin
        pairs++;
        sum_x += x;
        sum_y += y;
        sum_xy += x * y;
        sum_xx += x * x;
        sum_yy += y * y;
      end
      if (!is_last) return;
      n = WIDE_W'(pairs);
      wx = WIDE_W'(sum_x);
      wy = WIDE_W'(sum_y);
      wxy = WIDE_W'(sum_xy);
      wxx = WIDE_W'(sum_xx);
      wyy = WIDE_W'(sum_yy);
      p = n * wxy;
      q = wx * wy;
      num = (p >= q) ? p - q : q - p;
      dx = spread(n, wxx, wx);
      dy = spread(n, wyy, wy);
      r.zero_var = (dx == 0) || (dy == 0);
      r.ovf = dropped;
      r.magnitude = (!r.zero_var && !dropped) ? root_ratio(num, dx, dy) : '0;
      r.count = pairs[CNT_W-1:0];
      pending_results.push_back(r);
      clear();
    endfunction

    // Compare one delivered result with the oldest one owed
    function void check_result(corr_result_t got);
      corr_result_t want;
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("unexpected result: mag=%0d zv=%0b ovf=%0b n=%0d",
                   got.magnitude, got.zero_var, got.ovf, got.count);
        return;
      end
      want = pending_results.pop_front();
      if (got.magnitude !== want.magnitude || got.zero_var !== want.zero_var ||
          got.ovf !== want.ovf || got.count !== want.count) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("mismatch: want mag=%0d zv=%0b ovf=%0b n=%0d, got mag=%0d zv=%0b ovf=%0b n=%0d",
                   want.magnitude, want.zero_var, want.ovf, want.count,
                   got.magnitude, got.zero_var, got.ovf, got.count);
      end
    endfunction

    // Count results still owed at the end
    function void close_out();
      if (pending_results.size() != 0) begin
        errors += pending_results.size();
        if (errors <= REPORT_LIMIT)
          $display("%0d results never arrived", pending_results.size());
      end
    endfunction
  endclass

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_stall;
  logic [SAMPLE_W-1:0] data_value;
  logic [SAMPLE_W-1:0] model_value;
  logic                last;
  logic                out_valid;
  logic                out_stall;
  logic [RES_W-1:0]    correlation_magnitude;
  logic                zero_variance;
  logic                overflow;
  logic [CNT_W-1:0]    pair_count;

  corr_scoreboard sb;
  bit steady;
  int results_seen;
  int quiet_cycles;

  pearson_correlation_magnitude DUT (
    .clk                   (clk),
    .rst                   (rst),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .data_value            (data_value),
    .model_value           (model_value),
    .last                  (last),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .correlation_magnitude (correlation_magnitude),
    .zero_variance         (zero_variance),
    .overflow              (overflow),
    .pair_count            (pair_count)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Observe transfers on both channels; end the run if nothing moves
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall)
        sb.note_pair(data_value, model_value, last);
      if (out_valid && !out_stall) begin
        sb.check_result('{correlation_magnitude, zero_variance, overflow, pair_count});
        results_seen++;
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // Receiver: random stalls, one long hold-off once results are flowing
  initial begin
    int hold_left;
    bit held;
    hold_left = 0;
    held = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (!held && results_seen >= HOLD_AFTER) begin
        held = 1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !steady && ($urandom_range(99) < STALL_PCT);
      end
    end
  end

  // Offer one pair, with a random idle gap first; return after the transfer
  task automatic send_pair(input logic [SAMPLE_W-1:0] data,
                           input logic [SAMPLE_W-1:0] model, input logic is_last);
    while (!steady && $urandom_range(99) < STALL_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    data_value <= data;
    model_value <= model;
    last <= is_last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // Send a whole set whose content follows the given shape
  task automatic send_set(input int len, input set_shape_t shape);
    logic [SAMPLE_W-1:0] x, y, flat;
    flat = SAMPLE_W'($urandom_range(65535));
    for (int i = 0; i < len; i++) begin
      x = SAMPLE_W'($urandom_range(65535));
      y = SAMPLE_W'($urandom_range(65535));
      unique case (shape)
        SHAPE_SMALL: begin
          x = SAMPLE_W'($urandom_range(3));
          y = SAMPLE_W'($urandom_range(3));
        end
        SHAPE_EXTREME: begin
          x = $urandom_range(1) ? '1 : '0;
          y = $urandom_range(1) ? '1 : '0;
        end
        SHAPE_SAME:       y = x;
        SHAPE_MIRROR:     y = ~x;
        SHAPE_HALF:       y = (x >> 1) + (flat >> 1);
        SHAPE_FLAT_DATA:  x = flat;
        SHAPE_FLAT_MODEL: y = flat;
        default: ;
      endcase
      send_pair(x, y, i == len - 1);
    end
  endtask

  initial begin
    int sent, sets, len, pick;
    set_shape_t shape;
    sb = new();
    rst = 1'b1;
    in_valid = 1'b0;
    data_value = '0;
    model_value = '0;
    last = 1'b0;
    steady = 0;
    results_seen = 0;
    quiet_cycles = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Single pair: zero variance
    send_pair(16'd0, 16'd0, 1'b1);
    // Extremes, perfect positive and perfect negative correlation
    send_pair(16'd0, 16'd0, 1'b0);
    send_pair(16'hFFFF, 16'hFFFF, 1'b1);
    send_pair(16'd0, 16'hFFFF, 1'b0);
    send_pair(16'hFFFF, 16'd0, 1'b1);
    // Both sides constant at full scale
    repeat (2) send_pair(16'hFFFF, 16'hFFFF, 1'b0);
    send_pair(16'hFFFF, 16'hFFFF, 1'b1);
    // Constant data, then constant model
    send_pair(16'd7, 16'd1, 1'b0);
    send_pair(16'd7, 16'd2, 1'b0);
    send_pair(16'd7, 16'd3, 1'b1);
    send_pair(16'd1, 16'd9, 1'b0);
    send_pair(16'd2, 16'd9, 1'b1);
    // Partial correlation
    send_pair(16'd1, 16'd2, 1'b0);
    send_pair(16'd2, 16'd1, 1'b0);
    send_pair(16'd3, 16'd5, 1'b0);
    send_pair(16'd4, 16'd3, 1'b1);
    send_pair(16'hFFFF, 16'd1, 1'b0);
    send_pair(16'd0, 16'hFFFF, 1'b0);
    send_pair(16'h8000, 16'h7FFF, 1'b1);

    // Random sets, mostly short, with a stretch of back-to-back traffic
    sent = 0;
    sets = 0;
    while (sent < RANDOM_PAIRS) begin
      steady = (sets >= 10 && sets < 22);
      pick = $urandom_range(99);
      len = (pick < 70) ? $urandom_range(1, 8) :
            (pick < 95) ? $urandom_range(9, 40) : $urandom_range(41, 200);
      if (len > RANDOM_PAIRS - sent) len = RANDOM_PAIRS - sent;
      shape = ($urandom_range(99) < 40) ? SHAPE_RANDOM :
              set_shape_t'($urandom_range(SHAPE_FLAT_MODEL));
      send_set(len, shape);
      sent += len;
      sets++;
    end
    steady = 0;
    in_valid <= 1'b0;

    // Drain outstanding results, then watch for strays
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    sb.close_out();
    if (sb.errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
